// ===== design/fwdd_pkg.sv =====
package fwdd_pkg;

  localparam int FWDD_NUM_PORTS  = 4;
  localparam int FWDD_NUM_ROUTES = 16;
  localparam int FWDD_LANES      = 16;

  localparam logic [15:0] ETYPE_ARP = 16'h0806;
  localparam logic [15:0] ETYPE_IP  = 16'h0800;

  localparam logic [2:0] ACT_DROP      = 3'd0;
  localparam logic [2:0] ACT_ARP_REPLY = 3'd1;
  localparam logic [2:0] ACT_ARP_LEARN = 3'd2;
  localparam logic [2:0] ACT_ECHO      = 3'd3;
  localparam logic [2:0] ACT_ERROR     = 3'd4;
  localparam logic [2:0] ACT_FORWARD   = 3'd5;
  localparam logic [2:0] ACT_WRITTEN   = 3'd6;

  localparam logic [7:0] ICMP_UNREACH   = 8'd3;
  localparam logic [7:0] ICMP_TIME_EXC  = 8'd11;
  localparam logic [7:0] ICMP_ECHO_REQ  = 8'd8;
  localparam logic [3:0] CODE_NET       = 4'd0;
  localparam logic [3:0] CODE_PROTO     = 4'd2;
  localparam logic [3:0] CODE_PORT      = 4'd3;

  localparam logic [7:0] PROTO_ICMP = 8'd1;
  localparam logic [7:0] PROTO_TCP  = 8'd6;
  localparam logic [7:0] PROTO_UDP  = 8'd17;

  localparam logic [2:0] REG_PORT_IP_0     = 3'd0;
  localparam logic [2:0] REG_PORT_IP_1     = 3'd1;
  localparam logic [2:0] REG_PORT_IP_2     = 3'd2;
  localparam logic [2:0] REG_PORT_IP_3     = 3'd3;
  localparam logic [2:0] REG_PORTS_IN_USE  = 3'd4;
  localparam logic [2:0] REG_ROUTES_IN_USE = 3'd5;

  typedef struct packed {
    logic        kind;
    logic [1:0]  port;
    logic [15:0] ethertype;
    logic [15:0] arp_hw_type;
    logic [15:0] arp_proto_type;
    logic [15:0] arp_opcode;
    logic [31:0] target_addr;
    logic [31:0] second_addr;
    logic [3:0]  route_slot;
    logic [7:0]  ip_protocol;
    logic [7:0]  ip_ttl;
    logic [7:0]  icmp_kind;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  action;
    logic [7:0]  icmp_type_out;
    logic [3:0]  icmp_code_out;
    logic [1:0]  out_port;
    logic [31:0] result_addr;
  } out_item_t;

  typedef struct packed {
    logic       hit;
    logic [5:0] len;
    logic [1:0] rport;
  } lane_t;

  // leading ones end at the highest zero bit
  function automatic logic [5:0] prefix_len(input logic [31:0] m);
    logic [5:0] n;
    n = 6'd32;
    for (int i = 0; i < 32; i++) begin
      if (!m[i]) n = 6'(31 - i);
    end
    return n;
  endfunction

  // later lane b wins a tie
  function automatic lane_t pick(input lane_t a, input lane_t b);
    if (b.hit && (!a.hit || b.len >= a.len)) return b;
    return a;
  endfunction

endpackage

// ===== design/fwdd_route_table.sv =====
module fwdd_route_table import fwdd_pkg::*; #(
  parameter int NUM_ROUTES = FWDD_NUM_ROUTES
) (
  input  logic              clk,
  input  logic              en,
  input  logic              wr,
  input  logic [3:0]        wr_slot,
  input  logic [31:0]       wr_dest,
  input  logic [31:0]       wr_mask,
  input  logic [1:0]        wr_port,
  input  logic [31:0]       lookup_addr,
  input  logic [4:0]        routes_in_use,
  output lane_t [FWDD_LANES-1:0] lanes
);

  localparam int DEPTH = (NUM_ROUTES < FWDD_LANES) ? NUM_ROUTES : FWDD_LANES;

  for (genvar i = 0; i < FWDD_LANES; i++) begin : g_lane
    if (i < DEPTH) begin : g_used
      logic [31:0] dest;
      logic [31:0] mask;
      logic [1:0]  rport;

      always_ff @(posedge clk) begin
        if (wr && wr_slot == 4'(i)) begin
          dest  <= wr_dest;
          mask  <= wr_mask;
          rport <= wr_port;
        end
      end

      always_ff @(posedge clk) begin
        if (en) begin
          lanes[i].hit   <= (5'(i) < routes_in_use) && (dest == (mask & lookup_addr));
          lanes[i].len   <= prefix_len(mask);
          lanes[i].rport <= rport;
        end
      end
    end else begin : g_empty
      assign lanes[i] = '0;
    end
  end

endmodule

// ===== design/fwdd_lpm_reduce.sv =====
module fwdd_lpm_reduce import fwdd_pkg::*; (
  input  logic                   clk,
  input  logic                   en,
  input  lane_t [FWDD_LANES-1:0] lanes,
  output lane_t                  best
);

  lane_t [3:0] quad;

  // 16 to 4, then 4 to 1, one register level each
  always_ff @(posedge clk) begin
    if (en) begin
      for (int q = 0; q < 4; q++) begin
        quad[q] <= pick(pick(lanes[4*q], lanes[4*q+1]), pick(lanes[4*q+2], lanes[4*q+3]));
      end
      best <= pick(pick(quad[0], quad[1]), pick(quad[2], quad[3]));
    end
  end

endmodule

// ===== design/ipv4_forwarding_decision_core.sv =====
// IPv4 forwarding decision core.
// Input channel in_valid/in_ready/in_item carries frame headers to classify
// and route table writes (kind set). Output channel out_valid/out_ready/
// out_item gives exactly one result item per input item, in order.
// Configuration: cfg_we/cfg_addr/cfg_wdata write port addresses, port count
// and route count; write only while the core is idle.
// Throughput: one item per cycle unless the output stalls; the pipeline is
// five register levels (input, lane compare, 16-to-4 reduce, 4-to-1 reduce,
// output) all moving on one advance enable.
// A route write updates the table at the edge it is accepted, so the next
// frame already sees it.
// Reset clears valid bits and configuration (ports_in_use 4, routes 0); the
// route table holds garbage until written.
// When the receiver stalls with a result waiting, the whole pipeline holds
// and in_ready drops; nothing is lost or repeated.
module ipv4_forwarding_decision_core import fwdd_pkg::*; #(
  parameter int NUM_PORTS  = FWDD_NUM_PORTS,
  parameter int NUM_ROUTES = FWDD_NUM_ROUTES
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_item,
  input  logic      cfg_we,
  input  logic [2:0] cfg_addr,
  input  logic [31:0] cfg_wdata
);

  logic [31:0] port_ip [4];
  logic [2:0]  ports_in_use;
  logic [4:0]  routes_in_use;

  logic      en;
  logic      accept;
  logic      v0, v1, v2, v3;
  in_item_t  s0;
  out_item_t res_next;
  logic      lpm_next;
  out_item_t r1, r2, r3;
  logic      lpm1, lpm2, lpm3;
  lane_t [FWDD_LANES-1:0] lanes;
  lane_t     best;

  // advance every stage together whenever the output slot frees up
  assign en       = !out_valid || out_ready;
  assign in_ready = en;
  assign accept   = in_valid && en;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 4; i++) port_ip[i] <= '0;
      ports_in_use  <= 3'd4;
      routes_in_use <= '0;
    end else if (cfg_we) begin
      if (cfg_addr <= REG_PORT_IP_3) begin
        port_ip[cfg_addr[1:0]] <= cfg_wdata;
      end else if (cfg_addr == REG_PORTS_IN_USE) begin
        ports_in_use <= cfg_wdata[2:0];
      end else if (cfg_addr == REG_ROUTES_IN_USE) begin
        routes_in_use <= cfg_wdata[4:0];
      end
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0; v1 <= 1'b0; v2 <= 1'b0; v3 <= 1'b0; out_valid <= 1'b0;
    end else if (en) begin
      v0 <= in_valid; v1 <= v0; v2 <= v1; v3 <= v2; out_valid <= v3;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (en) s0 <= in_item;
  end

  // route writes land in the table at acceptance; out-of-range slots are dropped
  fwdd_route_table #(.NUM_ROUTES(NUM_ROUTES)) u_table (
    .clk          (clk),
    .en           (en),
    .wr           (accept && in_item.kind && ({5'd0, in_item.route_slot} < 9'(NUM_ROUTES))),
    .wr_slot      (in_item.route_slot),
    .wr_dest      (in_item.target_addr),
    .wr_mask      (in_item.second_addr),
    .wr_port      (in_item.port),
    .lookup_addr  (s0.target_addr),
    .routes_in_use(routes_in_use),
    .lanes        (lanes)
  );

  fwdd_lpm_reduce u_reduce (
    .clk  (clk),
    .en   (en),
    .lanes(lanes),
    .best (best)
  );

  // decide everything but the route lookup from the input register
  always_comb begin
    logic [31:0] own;
    logic        other_port;
    own        = port_ip[s0.port];
    other_port = 1'b0;
    for (int i = 0; i < NUM_PORTS; i++) begin
      other_port = other_port
                 | ((3'(i) < ports_in_use) && (port_ip[i] == s0.target_addr));
    end
    res_next = '0;
    lpm_next = 1'b0;
    if (s0.kind) begin
      if ({5'd0, s0.route_slot} < 9'(NUM_ROUTES)) res_next.action = ACT_WRITTEN;
    end else if (s0.ethertype == ETYPE_ARP) begin
      if (s0.arp_hw_type == 16'd1 && s0.arp_proto_type == ETYPE_IP && s0.target_addr == own) begin
        if (s0.arp_opcode == 16'd1) begin
          res_next.action   = ACT_ARP_REPLY;
          res_next.out_port = s0.port;
        end else if (s0.arp_opcode == 16'd2) begin
          res_next.action      = ACT_ARP_LEARN;
          res_next.out_port    = s0.port;
          res_next.result_addr = s0.second_addr;
        end
      end
    end else if (s0.ethertype == ETYPE_IP) begin
      res_next.out_port = s0.port;
      if (s0.target_addr == own) begin
        if (s0.ip_protocol == PROTO_ICMP) begin
          if (s0.ip_ttl == 8'd1) begin
            res_next.action        = ACT_ERROR;
            res_next.icmp_type_out = ICMP_TIME_EXC;
          end else if (s0.icmp_kind == ICMP_ECHO_REQ) begin
            res_next.action = ACT_ECHO;
          end else begin
            res_next.out_port = '0;
          end
        end else begin
          res_next.action        = ACT_ERROR;
          res_next.icmp_type_out = ICMP_UNREACH;
          res_next.icmp_code_out = (s0.ip_protocol == PROTO_UDP || s0.ip_protocol == PROTO_TCP)
                                   ? CODE_PORT : CODE_PROTO;
        end
      end else if (other_port) begin
        res_next.action        = ACT_ERROR;
        res_next.icmp_type_out = ICMP_UNREACH;
        res_next.icmp_code_out = CODE_NET;
      end else if (s0.ip_ttl == 8'd1) begin
        res_next.action        = ACT_ERROR;
        res_next.icmp_type_out = ICMP_TIME_EXC;
      end else begin
        // transit: hold the destination; the lookup settles the rest
        res_next.result_addr = s0.target_addr;
        lpm_next             = 1'b1;
      end
    end
  end

  // carry the partial result alongside the lookup stages
  always_ff @(posedge clk) begin
    if (en) begin
      r1 <= res_next; lpm1 <= lpm_next;
      r2 <= r1;       lpm2 <= lpm1;
      r3 <= r2;       lpm3 <= lpm2;
    end
  end

  // merge the lookup result into the output register
  always_ff @(posedge clk) begin
    if (en) begin
      out_item <= r3;
      if (lpm3) begin
        if (best.hit) begin
          out_item.action   <= ACT_FORWARD;
          out_item.out_port <= best.rport;
        end else begin
          out_item.action        <= ACT_ERROR;
          out_item.icmp_type_out <= ICMP_UNREACH;
          out_item.icmp_code_out <= CODE_NET;
          out_item.result_addr   <= '0;
        end
      end
    end
  end

  a_forward_needs_routes: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.action == ACT_FORWARD |-> routes_in_use != 5'd0)
    else $error("forward result with no routes searched");

  a_error_type: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.action == ACT_ERROR |->
      out_item.icmp_type_out == ICMP_UNREACH || out_item.icmp_type_out == ICMP_TIME_EXC)
    else $error("icmp error with bad type");

  a_no_icmp_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.action != ACT_ERROR |->
      out_item.icmp_type_out == 8'd0 && out_item.icmp_code_out == 4'd0)
    else $error("icmp fields set on non-error result");

endmodule
